// File: rtl/deadline_timer_queue_unit_macros.svh
// Assertion macros for the deadline timer queue RTL.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef DEADLINE_TIMER_QUEUE_UNIT_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_UNIT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define DTQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the standard clk_i / rst_ni pair.
`define DTQ_ASSERT_STD(label, prop, msg) \
  `DTQ_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/dtq_pkg.sv
// Shared types and constants of the deadline timer queue.
// No dependencies; imported by every RTL module of the block.
package dtq_pkg;

  localparam int unsigned QueueDepth   = 64;
  localparam int unsigned IdxW         = $clog2(QueueDepth);
  localparam int unsigned CntW         = IdxW + 1;
  localparam int unsigned MaxTimeoutMs = 100;
  localparam int unsigned TimeoutW     = $clog2(MaxTimeoutMs + 1);
  localparam int unsigned TickW        = 63;
  localparam int unsigned KeyW         = 32;
  localparam int unsigned HandleW      = 32;
  localparam int unsigned LenW         = 31;
  localparam int unsigned StampW       = 32;
  localparam int unsigned CfgW         = 32;
  localparam int unsigned DivStepW     = $clog2(TickW);

  typedef enum logic [2:0] {
    OpPostDelay = 3'd0,
    OpPostDue   = 3'd1,
    OpResched   = 3'd2,
    OpCollect   = 3'd3,
    OpTimeout   = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    StsQueued      = 3'd0,
    StsDispatch    = 3'd1,
    StsNothingDue  = 3'd2,
    StsFullDropped = 3'd3,
    StsKeyNotFound = 3'd4,
    StsTimeout     = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    CfgTicksPerUs = 1'b0,
    CfgTicksPerMs = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StInsert,
    StScan,
    StDecide,
    StRemRd,
    StRemWr,
    StDivWait
  } state_e;

  typedef struct packed {
    logic [TickW-1:0]   due;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
    logic [LenW-1:0]    length;
    logic [StampW-1:0]  stamp;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [TickW-1:0] dividend;
    logic [CfgW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [TimeoutW-1:0] quot;
  } div_rsp_t;

endpackage

// File: rtl/deadline_timer_queue_unit.sv
// Deadline timer queue top level: entry memory, scan sequencer and result register.
// Depends on dtq_pkg, dtq_divider and deadline_timer_queue_unit_macros.svh.
//
// Usage: a request is taken when start is high and busy is low; the opcode and
// request fields are sampled at that edge. Exactly one result follows: done_o
// is high for one cycle with status_o and the dispatch / timeout fields. The
// receiver cannot stall, so the result is dropped onto the ports and gone.
// Registers ticks_per_us_q16 (index 0), ticks_per_ms (index 1): the user must write
// them through cfg_we_i / cfg_idx_i / cfg_wdata_i while the block is idle;
// the block itself does not enforce this.
// Sequence: zero-delay posts and unknown opcodes answer from StIdle, posts
// with a due tick through StInsert, posts with a delay through StMul (multiply)
// and StInsert. Pending entries sit unordered in one 64-deep memory with a
// registered read. Reschedule, collect and timeout scan every occupied slot, one
// read a cycle; StDecide then answers a not found reschedule or nothing-due
// collect, a repost passes through StMul and StInsert, a collect dispatch through
// StRemRd and StRemWr. Each discarded invalidated head is removed and starts a
// fresh scan. Timeout runs a bit-serial divide after StDecide unless the queue
// is empty or the earliest entry is already due. The next request is taken as
// early as the cycle in which done_o is high.
// Reset empties the queue at once (count and valid bits clear); the memory
// itself needs no clearing pass.
`include "deadline_timer_queue_unit_macros.svh"
module deadline_timer_queue_unit
  import dtq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                done_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic [2:0]          opcode_i,
  input  logic [TickW-1:0]    now_ticks_i,
  input  logic [KeyW-1:0]     key_i,
  input  logic [HandleW-1:0]  handle_i,
  input  logic [LenW-1:0]     length_i,
  input  logic [31:0]         delay_us_i,
  input  logic [TickW-1:0]    due_tick_i,
  output logic [2:0]          status_o,
  output logic [KeyW-1:0]     out_key_o,
  output logic [HandleW-1:0]  out_handle_o,
  output logic [LenW-1:0]     out_length_o,
  output logic [TimeoutW-1:0] timeout_ms_o
);

  // request latch
  logic [2:0]         op_q, op_d;
  logic [TickW-1:0]   now_q, now_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [HandleW-1:0] handle_q, handle_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [31:0]        delay_q, delay_d;
  logic [TickW-1:0]   due_in_q, due_in_d;

  // configuration
  logic [CfgW-1:0] tpu_q, tpm_q;

  // queue state
  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [StampW-1:0]   stamp_ctr_q, stamp_ctr_d;
  logic [QueueDepth-1:0] valid_q, valid_d;

  // entry memory
  entry_t          mem [QueueDepth];
  entry_t          rdata_q;
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  entry_t          mem_wdata;

  // scan
  logic [CntW-1:0] issue_q, issue_d;
  logic            rd_vld_q, rd_vld_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic            best_vld_q, best_vld_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  entry_t          best_q, best_d;
  logic            cand_ok, cand_before, scan_done;
  logic [StampW-1:0] stamp_diff;

  // arithmetic
  logic [63:0]     prod_q, prod_d;
  logic [TickW:0]  due_sum;
  logic [TickW-1:0] due_calc;
  logic [CntW-1:0] cnt_m1;
  logic [IdxW-1:0] last_idx;
  logic            full;

  // result
  logic                done_q, done_d;
  logic [2:0]          status_q, status_d;
  logic [KeyW-1:0]     okey_q, okey_d;
  logic [HandleW-1:0]  ohandle_q, ohandle_d;
  logic [LenW-1:0]     olen_q, olen_d;
  logic [TimeoutW-1:0] tmo_q, tmo_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic accept;
  assign accept   = start && !busy;
  assign busy     = (state_q != StIdle);
  assign cnt_m1   = cnt_q - CntW'(1);
  assign last_idx = cnt_m1[IdxW-1:0];
  assign full     = (cnt_q == CntW'(QueueDepth));

  // saturate the scaled delay sum at the top of the tick range
  assign due_sum  = {1'b0, now_q} + {{(TickW + 1 - 48){1'b0}}, prod_q[63:16]};
  assign due_calc = due_sum[TickW] ? '1 : due_sum[TickW-1:0];

  // candidate of the scan: earlier due, ties by serial stamp order
  assign stamp_diff  = rdata_q.stamp - best_q.stamp;
  assign cand_before = (rdata_q.due < best_q.due) ||
                       ((rdata_q.due == best_q.due) && stamp_diff[StampW-1]);
  assign cand_ok     = (op_q != OpResched) ||
                       (valid_q[rd_idx_q] && (rdata_q.key == key_q));
  assign scan_done   = (issue_q == cnt_q) && !rd_vld_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          case (opcode_i) inside
            OpPostDelay: state_d = (delay_us_i == '0) ? StIdle : StMul;
            OpPostDue:   state_d = StInsert;
            OpResched, OpCollect, OpTimeout: state_d = StScan;
            default:     state_d = StIdle;
          endcase
        end
      end
      StMul:    state_d = StInsert;
      StInsert: state_d = StIdle;
      StScan:   state_d = scan_done ? StDecide : StScan;
      StDecide: begin
        case (op_q)
          OpResched: state_d = (!best_vld_q || delay_q == '0) ? StIdle : StMul;
          OpCollect: state_d = (!best_vld_q || best_q.due > now_q) ? StIdle : StRemRd;
          OpTimeout: state_d = (!best_vld_q || best_q.due <= now_q) ? StIdle : StDivWait;
          default:   state_d = StIdle;
        endcase
      end
      StRemRd:   state_d = StRemWr;
      StRemWr:   state_d = valid_q[best_idx_q] ? StIdle : StScan;
      StDivWait: state_d = div_rsp.done ? StIdle : StDivWait;
      default:   state_d = StIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_d        = op_q;
    now_d       = now_q;
    key_d       = key_q;
    handle_d    = handle_q;
    len_d       = len_q;
    delay_d     = delay_q;
    due_in_d    = due_in_q;
    cnt_d       = cnt_q;
    stamp_ctr_d = stamp_ctr_q;
    valid_d     = valid_q;
    issue_d     = issue_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    best_vld_d  = best_vld_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    prod_d      = prod_q;
    done_d      = 1'b0;
    status_d    = status_q;
    okey_d      = okey_q;
    ohandle_d   = ohandle_q;
    olen_d      = olen_q;
    tmo_d       = tmo_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[IdxW-1:0];
    mem_wdata   = '{due: due_calc, key: key_q, handle: handle_q, length: len_q,
                    stamp: stamp_ctr_q};
    mem_re      = 1'b0;
    mem_raddr   = issue_q[IdxW-1:0];
    div_req     = '{start: 1'b0, dividend: best_q.due - now_q,
                    divisor: (tpm_q == '0) ? CfgW'(1) : tpm_q};

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          op_d     = opcode_i;
          now_d    = now_ticks_i;
          key_d    = key_i;
          handle_d = handle_i;
          len_d    = length_i;
          delay_d  = delay_us_i;
          due_in_d = due_tick_i;
          issue_d    = '0;
          best_vld_d = 1'b0;
          case (opcode_i) inside
            OpPostDelay: begin
              if (delay_us_i == '0) begin
                done_d    = 1'b1;
                status_d  = StsDispatch;
                okey_d    = key_i;
                ohandle_d = handle_i;
                olen_d    = length_i;
                tmo_d     = '0;
              end
            end
            OpPostDue, OpResched, OpCollect, OpTimeout: ;
            default: begin
              done_d    = 1'b1;
              status_d  = StsNothingDue;
              okey_d    = '0;
              ohandle_d = '0;
              olen_d    = '0;
              tmo_d     = '0;
            end
          endcase
        end
      end
      StMul: begin
        prod_d = {32'b0, delay_q} * {32'b0, tpu_q};
      end
      StInsert: begin
        done_d    = 1'b1;
        okey_d    = '0;
        ohandle_d = '0;
        olen_d    = '0;
        tmo_d     = '0;
        if (full) begin
          status_d = StsFullDropped;
        end else begin
          status_d = StsQueued;
          mem_we   = 1'b1;
          if (op_q == OpPostDue) begin
            mem_wdata.due = due_in_q;
          end
          valid_d[cnt_q[IdxW-1:0]] = 1'b1;
          stamp_ctr_d = stamp_ctr_q + StampW'(1);
          cnt_d       = cnt_q + CntW'(1);
        end
      end
      StScan: begin
        // issue one read per cycle, fold in the entry read last cycle
        if (issue_q < cnt_q) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = issue_q[IdxW-1:0];
          issue_d  = issue_q + CntW'(1);
        end
        if (rd_vld_q && cand_ok && (!best_vld_q || cand_before)) begin
          best_vld_d = 1'b1;
          best_idx_d = rd_idx_q;
          best_d     = rdata_q;
        end
      end
      StDecide: begin
        okey_d    = '0;
        ohandle_d = '0;
        olen_d    = '0;
        tmo_d     = '0;
        case (op_q)
          OpResched: begin
            if (!best_vld_q) begin
              done_d   = 1'b1;
              status_d = StsKeyNotFound;
            end else begin
              valid_d[best_idx_q] = 1'b0;
              if (delay_q == '0) begin
                done_d    = 1'b1;
                status_d  = StsDispatch;
                okey_d    = key_q;
                ohandle_d = handle_q;
                olen_d    = len_q;
              end
            end
          end
          OpCollect: begin
            if (!best_vld_q || best_q.due > now_q) begin
              done_d   = 1'b1;
              status_d = StsNothingDue;
            end
          end
          OpTimeout: begin
            if (!best_vld_q) begin
              done_d   = 1'b1;
              status_d = StsTimeout;
              tmo_d    = TimeoutW'(MaxTimeoutMs);
            end else if (best_q.due <= now_q) begin
              done_d   = 1'b1;
              status_d = StsTimeout;
            end else begin
              div_req.start = 1'b1;
            end
          end
          default: ;
        endcase
      end
      StRemRd: begin
        mem_re    = 1'b1;
        mem_raddr = last_idx;
      end
      StRemWr: begin
        // move the last slot into the hole left by the head
        mem_we    = 1'b1;
        mem_waddr = best_idx_q;
        mem_wdata = rdata_q;
        valid_d[best_idx_q] = valid_q[last_idx];
        valid_d[last_idx]   = 1'b0;
        cnt_d = cnt_m1;
        if (valid_q[best_idx_q]) begin
          done_d    = 1'b1;
          status_d  = StsDispatch;
          okey_d    = best_q.key;
          ohandle_d = best_q.handle;
          olen_d    = best_q.length;
          tmo_d     = '0;
        end else begin
          issue_d    = '0;
          best_vld_d = 1'b0;
        end
      end
      StDivWait: begin
        if (div_rsp.done) begin
          done_d   = 1'b1;
          status_d = StsTimeout;
          tmo_d    = div_rsp.quot;
        end
      end
      default: ;
    endcase
  end

  dtq_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      stamp_ctr_q <= '0;
      valid_q     <= '0;
      rd_vld_q    <= 1'b0;
      best_vld_q  <= 1'b0;
      done_q      <= 1'b0;
      tpu_q       <= CfgW'(655360);
      tpm_q       <= CfgW'(10000);
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      stamp_ctr_q <= stamp_ctr_d;
      valid_q     <= valid_d;
      rd_vld_q    <= rd_vld_d;
      best_vld_q  <= best_vld_d;
      done_q      <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgTicksPerUs: tpu_q <= cfg_wdata_i;
          CfgTicksPerMs: tpm_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    now_q      <= now_d;
    key_q      <= key_d;
    handle_q   <= handle_d;
    len_q      <= len_d;
    delay_q    <= delay_d;
    due_in_q   <= due_in_d;
    issue_q    <= issue_d;
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    prod_q     <= prod_d;
    status_q   <= status_d;
    okey_q     <= okey_d;
    ohandle_q  <= ohandle_d;
    olen_q     <= olen_d;
    tmo_q      <= tmo_d;
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign out_key_o    = okey_q;
  assign out_handle_o = ohandle_q;
  assign out_length_o = olen_q;
  assign timeout_ms_o = tmo_q;

  `DTQ_ASSERT_STD(a_cnt_bound, cnt_q <= CntW'(QueueDepth), "entry count past queue depth")
  `DTQ_ASSERT_STD(a_done_idle, done_q |-> (state_q == StIdle), "result shown while busy")
  `DTQ_ASSERT_STD(a_start_acts, (start && !busy) |=> (busy || done_q), "request lost")
  `DTQ_ASSERT_STD(a_insert_room, (mem_we && state_q == StInsert) |-> !full, "insert into full queue")

endmodule

// File: rtl/dtq_divider.sv
// Bit-serial restoring divider for the timeout query: ceil(dividend / divisor),
// clamped to MaxTimeoutMs. Depends on dtq_pkg.
module dtq_divider
  import dtq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                busy_q, busy_d;
  logic                fin_q, fin_d;
  logic                done_q, done_d;
  logic [DivStepW-1:0] step_q, step_d;
  logic [TickW-1:0]    dvd_q, dvd_d;
  logic [TickW-1:0]    quo_q, quo_d;
  logic [CfgW-1:0]     rem_q, rem_d;
  logic [CfgW-1:0]     dvs_q, dvs_d;
  logic [TimeoutW-1:0] quot_q, quot_d;
  logic [CfgW:0]       rem_sh;
  logic [CfgW:0]       rem_sub;
  logic                fits;

  assign rem_sh  = {rem_q, dvd_q[TickW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = DivStepW'(TickW - 1);
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      quo_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      // one quotient bit per cycle
      dvd_d = {dvd_q[TickW-2:0], 1'b0};
      quo_d = {quo_q[TickW-2:0], fits};
      rem_d = fits ? rem_sub[CfgW-1:0] : rem_sh[CfgW-1:0];
      step_d = step_q - DivStepW'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
    if (fin_q) begin
      done_d = 1'b1;
      if (quo_q >= TickW'(MaxTimeoutMs)) begin
        quot_d = TimeoutW'(MaxTimeoutMs);
      end else begin
        quot_d = quo_q[TimeoutW-1:0] + TimeoutW'(rem_q != '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule
